// ===== design/pubs_pkg.sv =====
// Shared types and constants for the paced uplink bit serializer.
// No dependencies; used by pubs_core and paced_uplink_bit_serializer.

package pubs_pkg;

	localparam int unsigned WIN_W      = 8;
	localparam int unsigned LEFT_W     = 5;
	localparam int unsigned FRAME_W    = 16;
	localparam int unsigned DATA_W     = 15;
	localparam int unsigned KEY_W      = 5;
	localparam int unsigned TALLY_W    = 32;

	// Pacing window length in ticks; a bit may go out once the window is full.
	localparam logic [WIN_W-1:0]  BIT_PULSES = WIN_W'(13);
	localparam logic [LEFT_W-1:0] FRAME_BITS = LEFT_W'(FRAME_W);

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_DATA = 2'd1,
		MODE_KEY  = 2'd2,
		MODE_BIT  = 2'd3
	} mode_t;

	typedef struct packed {
		logic               pulse_issued;
		logic               pulse_up;
		logic               too_fast;
		logic               bit_refused;
		logic               busy_res;
		logic [TALLY_W-1:0] accepted_count;
		logic [TALLY_W-1:0] refused_count;
		logic [TALLY_W-1:0] words_count;
	} result_t;

	// Key code word: code in the low bits, code again, then its complement.
	function automatic logic [DATA_W-1:0] key_word(input logic [KEY_W-1:0] code);
		return {~code, code, code};
	endfunction

endpackage

// ===== design/pubs_core.sv =====
// Serializer state and per-beat update: pacing window, pending frame, tallies.
// Depends on pubs_pkg.

module pubs_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         accept,
	input  logic [1:0]                   mode,
	input  logic [pubs_pkg::DATA_W-1:0]  data_word,
	input  logic [pubs_pkg::KEY_W-1:0]   key_code,
	input  logic                         bit_value,
	input  logic                         program_block,
	input  logic                         crosslink_select,
	output pubs_pkg::result_t            res
);

	logic                          cabin_block_q;
	logic [pubs_pkg::WIN_W-1:0]    win_q, win_n, win_eff;
	logic [pubs_pkg::FRAME_W-1:0]  frame_q, frame_n;
	logic [pubs_pkg::LEFT_W-1:0]   left_q, left_n;
	logic [pubs_pkg::TALLY_W-1:0]  acc_q, acc_n, ref_q, ref_n, words_q, words_n;
	logic [3:0]                    pos;
	logic                          listen, offer, offer_bit, send;
	pubs_pkg::mode_t               mode_e;

	assign mode_e = pubs_pkg::mode_t'(mode);
	assign listen = !cabin_block_q && !program_block && !crosslink_select;
	assign pos    = 4'(left_q - 5'd1);

	always_comb begin
		win_n     = win_q;
		frame_n   = frame_q;
		left_n    = left_q;
		acc_n     = acc_q;
		ref_n     = ref_q;
		words_n   = words_q;
		win_eff   = win_q;
		offer     = 1'b0;
		offer_bit = 1'b0;
		send      = 1'b0;
		res       = '0;
		unique case (mode_e)
			pubs_pkg::MODE_TICK: begin
				if (win_q < pubs_pkg::BIT_PULSES) begin
					win_eff = win_q + 8'd1;
				end
				win_n     = win_eff;
				offer     = (left_q != '0) && (win_eff >= pubs_pkg::BIT_PULSES);
				offer_bit = frame_q[pos];
			end
			pubs_pkg::MODE_DATA, pubs_pkg::MODE_KEY: begin
				send = 1'b1;
			end
			pubs_pkg::MODE_BIT: begin
				offer     = 1'b1;
				offer_bit = bit_value;
			end
			default: begin
				offer = 1'b0;
			end
		endcase

		if (send) begin
			frame_n = {1'b1, (mode_e == pubs_pkg::MODE_DATA) ? data_word
			                                                 : pubs_pkg::key_word(key_code)};
			left_n  = pubs_pkg::FRAME_BITS;
			words_n = words_q + 32'd1;
		end

		// Listening check comes first, so a blocked bit never reads as too fast.
		if (offer) begin
			if (!listen) begin
				ref_n           = ref_q + 32'd1;
				res.bit_refused = 1'b1;
			end else if (win_eff < pubs_pkg::BIT_PULSES) begin
				ref_n           = ref_q + 32'd1;
				res.bit_refused = 1'b1;
				res.too_fast    = 1'b1;
			end else begin
				acc_n            = acc_q + 32'd1;
				win_n            = '0;
				res.pulse_issued = 1'b1;
				res.pulse_up     = offer_bit;
				if (mode_e == pubs_pkg::MODE_TICK) begin
					left_n = left_q - 5'd1;
				end
			end
		end

		res.busy_res       = left_n != '0;
		res.accepted_count = acc_n;
		res.refused_count  = ref_n;
		res.words_count    = words_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cabin_block_q <= 1'b0;
		end else if (cfg_we) begin
			cabin_block_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= pubs_pkg::BIT_PULSES;
			frame_q <= '0;
			left_q  <= '0;
			acc_q   <= '0;
			ref_q   <= '0;
			words_q <= '0;
		end else if (accept) begin
			win_q   <= win_n;
			frame_q <= frame_n;
			left_q  <= left_n;
			acc_q   <= acc_n;
			ref_q   <= ref_n;
			words_q <= words_n;
		end
	end

	a_pulse_clears_window: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.pulse_issued |=> win_q == '0)
		else $error("window not cleared after pulse");

	a_send_loads_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode_e == pubs_pkg::MODE_DATA || mode_e == pubs_pkg::MODE_KEY)
		|=> left_q == pubs_pkg::FRAME_BITS && frame_q[pubs_pkg::FRAME_W-1])
		else $error("send did not load a flagged frame");

	a_left_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= pubs_pkg::FRAME_BITS)
		else $error("pending bit count out of range");

	a_one_tally_per_offer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (acc_q - $past(acc_q)) + (ref_q - $past(ref_q)) <= 32'd1)
		else $error("more than one bit tallied in a beat");

	a_window_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		win_q <= pubs_pkg::BIT_PULSES)
		else $error("pacing window past its limit");

endmodule

// ===== design/paced_uplink_bit_serializer.sv =====
// Top level of the paced uplink bit serializer: handshake and result register.
// Depends on pubs_pkg and pubs_core.

// Takes one beat per clock cycle when not stalled and returns exactly one
// result beat for it from the result register. Each beat (tick, frame send or
// direct bit) is settled combinationally by pubs_core; the input stalls only
// while a result sits in the result register and the output side stalls it.
// Write the cabin switch register only while no beat is in flight.

module paced_uplink_bit_serializer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       mode,
	input  logic [pubs_pkg::DATA_W-1:0]      data_word,
	input  logic [pubs_pkg::KEY_W-1:0]       key_code,
	input  logic                             bit_value,
	input  logic                             program_block,
	input  logic                             crosslink_select,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             pulse_issued,
	output logic                             pulse_up,
	output logic                             too_fast,
	output logic                             bit_refused,
	output logic                             busy_res,
	output logic [pubs_pkg::TALLY_W-1:0]     accepted_count,
	output logic [pubs_pkg::TALLY_W-1:0]     refused_count,
	output logic [pubs_pkg::TALLY_W-1:0]     words_count
);

	logic              accept;
	logic              out_valid_q;
	pubs_pkg::result_t res, res_q;

	// Hold the input only while the stored result cannot leave this cycle.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	pubs_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.accept           (accept),
		.mode             (mode),
		.data_word        (data_word),
		.key_code         (key_code),
		.bit_value        (bit_value),
		.program_block    (program_block),
		.crosslink_select (crosslink_select),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign pulse_issued   = res_q.pulse_issued;
	assign pulse_up       = res_q.pulse_up;
	assign too_fast       = res_q.too_fast;
	assign bit_refused    = res_q.bit_refused;
	assign busy_res       = res_q.busy_res;
	assign accepted_count = res_q.accepted_count;
	assign refused_count  = res_q.refused_count;
	assign words_count    = res_q.words_count;

endmodule

// ===== verif/paced_uplink_bit_serializer_test.sv =====
`timescale 1ns / 1ps
// Self-checking regression for paced_uplink_bit_serializer: directed and random beats,
// with random idling on both channels. Depends on pubs_pkg and the RTL only.

module paced_uplink_bit_serializer_test;

	// Pacing and frame model of the serializer, plus the queue of expected result beats.
	class uplink_scoreboard;
		logic [pubs_pkg::WIN_W-1:0]   window;
		logic [pubs_pkg::FRAME_W-1:0] frame;
		logic [pubs_pkg::LEFT_W-1:0]  left;
		logic [pubs_pkg::TALLY_W-1:0] accepted_n;
		logic [pubs_pkg::TALLY_W-1:0] refused_n;
		logic [pubs_pkg::TALLY_W-1:0] words_n;
		logic                         cabin;
		pubs_pkg::result_t            expected_q[$];
		int                           errors;
		int                           checked;
		int                           too_fast_n;

		function new();
			window     = pubs_pkg::BIT_PULSES;
			frame      = '0;
			left       = '0;
			accepted_n = '0;
			refused_n  = '0;
			words_n    = '0;
			cabin      = 1'b0;
			errors     = 0;
			checked    = 0;
			too_fast_n = 0;
		endfunction

		function void set_cabin(logic v);
			cabin = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Offer one bit to the link; returns 1 when it goes out as a pulse.
		function bit offer(logic one, logic hear, inout pubs_pkg::result_t r);
			if (!hear) begin
				refused_n++;
				r.bit_refused = 1'b1;
				return 1'b0;
			end
			if (window < pubs_pkg::BIT_PULSES) begin
				refused_n++;
				r.too_fast    = 1'b1;
				r.bit_refused = 1'b1;
				too_fast_n++;
				return 1'b0;
			end
			r.pulse_issued = 1'b1;
			r.pulse_up     = one;
			window         = '0;
			accepted_n++;
			return 1'b1;
		endfunction

		function void note_beat(pubs_pkg::mode_t m, logic [pubs_pkg::DATA_W-1:0] data,
			logic [pubs_pkg::KEY_W-1:0] key, logic b, logic pb, logic cs);
			pubs_pkg::result_t           r;
			logic                        hear;
			logic [pubs_pkg::DATA_W-1:0] w;
			r    = '0;
			hear = !cabin && !pb && !cs;
			case (m)
				pubs_pkg::MODE_TICK: begin
					if (window < pubs_pkg::BIT_PULSES)
						window++;
					if (left != 0 && window >= pubs_pkg::BIT_PULSES) begin
						if (offer(frame[left - 1'b1], hear, r))
							left--;
					end
				end
				pubs_pkg::MODE_DATA, pubs_pkg::MODE_KEY: begin
					w     = (m == pubs_pkg::MODE_DATA) ? data : {~key, key, key};
					frame = {1'b1, w};
					left  = pubs_pkg::FRAME_BITS;
					words_n++;
				end
				default: begin
					void'(offer(b, hear, r));
				end
			endcase
			r.busy_res       = (left != 0);
			r.accepted_count = accepted_n;
			r.refused_count  = refused_n;
			r.words_count    = words_n;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, logic [pubs_pkg::TALLY_W-1:0] got,
			logic [pubs_pkg::TALLY_W-1:0] exp);
			if (got !== exp)
				report($sformatf("beat %0d %s got 0x%0h expected 0x%0h", checked, name, got, exp));
		endtask

		task compare_flag(string name, logic got, logic exp);
			if (got !== exp)
				report($sformatf("beat %0d %s got %b expected %b", checked, name, got, exp));
		endtask

		task check_result(pubs_pkg::result_t got);
			pubs_pkg::result_t exp;
			if (expected_q.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			exp = expected_q.pop_front();
			compare_flag("pulse_issued", got.pulse_issued, exp.pulse_issued);
			compare_flag("pulse_up", got.pulse_up, exp.pulse_up);
			compare_flag("too_fast", got.too_fast, exp.too_fast);
			compare_flag("bit_refused", got.bit_refused, exp.bit_refused);
			compare_flag("busy_res", got.busy_res, exp.busy_res);
			compare_field("accepted_count", got.accepted_count, exp.accepted_count);
			compare_field("refused_count", got.refused_count, exp.refused_count);
			compare_field("words_count", got.words_count, exp.words_count);
			checked++;
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic                          cfg_wdata = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [1:0]                    mode = pubs_pkg::MODE_TICK;
	logic [pubs_pkg::DATA_W-1:0]   data_word = '0;
	logic [pubs_pkg::KEY_W-1:0]    key_code = '0;
	logic                          bit_value = 1'b0;
	logic                          program_block = 1'b0;
	logic                          crosslink_select = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          pulse_issued;
	logic                          pulse_up;
	logic                          too_fast;
	logic                          bit_refused;
	logic                          busy_res;
	logic [pubs_pkg::TALLY_W-1:0]  accepted_count;
	logic [pubs_pkg::TALLY_W-1:0]  refused_count;
	logic [pubs_pkg::TALLY_W-1:0]  words_count;

	uplink_scoreboard sb = new();
	bit               calm = 1'b0;

	paced_uplink_bit_serializer u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.data_word        (data_word),
		.key_code         (key_code),
		.bit_value        (bit_value),
		.program_block    (program_block),
		.crosslink_select (crosslink_select),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.pulse_issued     (pulse_issued),
		.pulse_up         (pulse_up),
		.too_fast         (too_fast),
		.bit_refused      (bit_refused),
		.busy_res         (busy_res),
		.accepted_count   (accepted_count),
		.refused_count    (refused_count),
		.words_count      (words_count)
	);

	always #6 clk = ~clk;

	// Mostly no gap, some short ones, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_beat(pubs_pkg::mode_t'(mode), data_word, key_code, bit_value,
					program_block, crosslink_select);
			if (out_valid && !out_stall)
				sb.check_result({pulse_issued, pulse_up, too_fast, bit_refused, busy_res,
					accepted_count, refused_count, words_count});
		end
	end

	initial begin
		int n;
		@(posedge clk iff arst_n);
		forever begin
			n = pick_gap();
			if (n == 0) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Present one beat and hold it until accepted.
	task drive_beat(pubs_pkg::mode_t m, logic [pubs_pkg::DATA_W-1:0] d,
		logic [pubs_pkg::KEY_W-1:0] k, logic b, logic pb, logic cs);
		in_valid         <= 1'b1;
		mode             <= m;
		data_word        <= d;
		key_code         <= k;
		bit_value        <= b;
		program_block    <= pb;
		crosslink_select <= cs;
		do @(posedge clk); while (in_stall);
	endtask

	task idle_gap(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task beat(pubs_pkg::mode_t m, logic [pubs_pkg::DATA_W-1:0] d,
		logic [pubs_pkg::KEY_W-1:0] k, logic b, logic pb, logic cs);
		drive_beat(m, d, k, b, pb, cs);
		idle_gap(pick_gap());
	endtask

	// Drop valid and hold until every expected result beat is back.
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task write_cabin(logic v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_cabin(v);
		cfg_we    <= 1'b0;
	endtask

	task random_beat();
		int                          r;
		logic                        pb;
		logic                        cs;
		logic [pubs_pkg::DATA_W-1:0] d;
		logic [pubs_pkg::KEY_W-1:0]  k;
		logic                        b;
		r  = $urandom_range(0, 999);
		pb = ($urandom_range(0, 19) == 0);
		cs = ($urandom_range(0, 19) == 0);
		d  = pubs_pkg::DATA_W'($urandom_range(0, 32767));
		k  = pubs_pkg::KEY_W'($urandom_range(0, 31));
		b  = 1'($urandom_range(0, 1));
		if (r < 4)
			beat(($urandom_range(0, 1) != 0) ? pubs_pkg::MODE_DATA : pubs_pkg::MODE_KEY,
				d, k, b, pb, cs);
		else if (r < 20)
			beat(pubs_pkg::MODE_BIT, d, k, b, pb, cs);
		else
			beat(pubs_pkg::MODE_TICK, d, k, b, pb, cs);
	endtask

	initial begin
		logic cabin_plan[5];
		int   size_plan[5];
		cabin_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		size_plan  = '{300, 120, 420, 90, 420};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_cabin(1'b0);

		// Window is full out of reset, so the first direct bit goes out.
		beat(pubs_pkg::MODE_BIT, '0, '0, 1'b1, 1'b0, 1'b0);
		beat(pubs_pkg::MODE_BIT, '0, '0, 1'b0, 1'b0, 1'b0);
		// Not listening wins over the pacing check.
		beat(pubs_pkg::MODE_BIT, '0, '0, 1'b1, 1'b1, 1'b0);
		beat(pubs_pkg::MODE_BIT, '0, '0, 1'b0, 1'b0, 1'b1);
		beat(pubs_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0, 1'b0);
		beat(pubs_pkg::MODE_DATA, 15'h7fff, 5'h1f, 1'b0, 1'b0, 1'b0);
		beat(pubs_pkg::MODE_DATA, 15'h0000, 5'h00, 1'b0, 1'b0, 1'b0);
		beat(pubs_pkg::MODE_KEY, 15'h0000, 5'h00, 1'b0, 1'b0, 1'b0);
		beat(pubs_pkg::MODE_KEY, 15'h7fff, 5'h1f, 1'b1, 1'b1, 1'b1);
		repeat (12) beat(pubs_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0, 1'b0);
		// Direct bit shares the window with the pending frame.
		beat(pubs_pkg::MODE_BIT, '0, '0, 1'b1, 1'b0, 1'b0);
		drain();

		foreach (size_plan[p]) begin
			write_cabin(cabin_plan[p]);
			calm = (p == 2);
			beat(($urandom_range(0, 1) != 0) ? pubs_pkg::MODE_DATA : pubs_pkg::MODE_KEY,
				pubs_pkg::DATA_W'($urandom_range(0, 32767)),
				pubs_pkg::KEY_W'($urandom_range(0, 31)), 1'b0, 1'b0, 1'b0);
			for (int i = 0; i < size_plan[p]; i++) begin
				random_beat();
				if (p == 0 && i == size_plan[p] / 2)
					drain();
			end
			drain();
		end
		calm = 1'b0;
		write_cabin(1'b0);

		drain();
		repeat (5) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d result beats never arrived", sb.pending()));
		$display("covered %0d result beats: %0d pulses, %0d refusals (%0d too fast), %0d frames",
			sb.checked, sb.accepted_n, sb.refused_n, sb.too_fast_n, sb.words_n);
		if (sb.errors == 0)
			$display("paced_uplink_bit_serializer regression: pass");
		else
			$display("paced_uplink_bit_serializer regression: fail");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("timeout waiting for the serializer");
		$display("paced_uplink_bit_serializer regression: fail");
		$finish;
	end

endmodule
